/* hdl/psb_pkg.sv */
// Package for the page-mapped sprite blitter: item kinds, queue entry type and states.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package psb_pkg;

    typedef enum logic [1:0]
    {
        KIND_HEADER = 2'd0,
        KIND_BYTE   = 2'd1,
        KIND_READ   = 2'd2,
        KIND_CLEAR  = 2'd3
    } kind_t;

    typedef struct packed
    {
        kind_t       kind;
        logic [6:0]  sprite_width;
        logic [10:0] sprite_len;
        logic [8:0]  x_pos;
        logic [7:0]  y_pos;
        logic        test_only;
        logic [7:0]  sprite_byte;
        logic [9:0]  frame_addr;
    } item_t;

    typedef enum logic [3:0]
    {
        ST_IDLE,
        ST_READ,
        ST_MODIFY,
        ST_FLUSH_AD,
        ST_FLUSH_RD,
        ST_FLUSH_WR,
        ST_FETCH,
        ST_CLEAR,
        ST_INIT,
        ST_OUT
    } state_t;

endpackage

/* hdl/psb_front.sv */
// Front end of the sprite blitter: accepts transactions and holds them in a short queue.
// Depends on psb_pkg.
`timescale 1ns / 1ps

module psb_front
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  psb_pkg::item_t in_item,
    output logic           q_valid,
    input  logic           q_ready,
    output psb_pkg::item_t q_item
);

    psb_pkg::item_t mem_reg [2];
    logic           wr_ptr_reg;
    logic           rd_ptr_reg;
    logic [1:0]     count_reg;
    logic           push;
    logic           pop;

    assign in_ready = (count_reg != 2'd2);
    assign q_valid  = (count_reg != 2'd0);
    assign q_item   = mem_reg[rd_ptr_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= in_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

/* hdl/psb_back.sv */
// Back end of the sprite blitter: frame store, row buffer and the sequencer for each item.
// Depends on psb_pkg.
`timescale 1ns / 1ps

module psb_back
#(
    parameter int FRAME_W          = 128,
    parameter int PAGES            = 8,
    parameter int MAX_SPRITE_BYTES = 1024,
    parameter int MAX_SPRITE_W     = 127
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_valid,
    output logic           q_ready,
    input  psb_pkg::item_t q_item,
    output logic           out_valid,
    input  logic           out_ready,
    output logic [7:0]     read_data,
    output logic           contact,
    output logic           sprite_done
);

    localparam int DEPTH   = FRAME_W * PAGES;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int LEN_W   = $clog2(MAX_SPRITE_BYTES + 1);
    localparam int PG_W    = LEN_W + 1;
    localparam int PY_W    = PG_W + 1;
    localparam int RB_W    = $clog2(MAX_SPRITE_W + 1);

    psb_pkg::state_t state_reg, state_next;

    logic [7:0]        frame_mem [DEPTH];
    logic [7:0]        row_mem   [MAX_SPRITE_W + 1];
    logic [7:0]        frame_q;
    logic [7:0]        row_q;

    logic [6:0]        width_reg;
    logic [LEN_W-1:0]  len_reg;
    logic signed [9:0] x_reg;
    logic signed [5:0] ybase_reg;
    logic [2:0]        ymod_reg;
    logic              test_reg;
    logic [LEN_W-1:0]  index_reg;
    logic [6:0]        col_reg;
    logic [PG_W-1:0]   page_reg;
    logic [6:0]        flush_reg;
    logic              hit_reg;
    logic [7:0]        byte_reg;
    logic [7:0]        raw_reg;
    logic              vis_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [ADDR_W-1:0] clr_reg;
    logic              done_reg;
    logic              rdsel_reg;

    logic [6:0]        w_sat;
    logic [LEN_W-1:0]  n_sat;
    logic signed [10:0] xs;
    logic signed [9:0] ys;
    logic signed [PY_W-1:0] py;
    logic              vis;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        spill;
    logic [7:0]        vbyte;
    logic [7:0]        cur;
    logic              active;
    logic              last;
    logic              clr_last;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_wa;
    logic [7:0]        mem_wd;

    assign xs = 11'(x_reg) + 11'($signed({1'b0, col_reg}));
    assign py = PY_W'(ybase_reg) + PY_W'($signed({1'b0, page_reg}));
    assign vis = (xs >= 0) && (xs < 11'(FRAME_W)) && (py >= 0) && (py < PY_W'(PAGES));
    assign addr = ADDR_W'(32'(py) * FRAME_W + 32'(xs));
    assign spill = (ymod_reg == 3'd0 || page_reg == '0) ? 8'd0
                 : 8'(row_q >> (4'd8 - {1'b0, ymod_reg}));
    assign cur = frame_q;
    assign active = (index_reg < len_reg);
    assign last = (index_reg + LEN_W'(1) == len_reg);
    assign clr_last = (clr_reg == ADDR_W'(DEPTH - 1));

    always_comb
    begin
        w_sat = (q_item.sprite_width == 7'd0) ? 7'd1 : q_item.sprite_width;
        if (32'(w_sat) > MAX_SPRITE_W)
        begin
            w_sat = 7'(MAX_SPRITE_W);
        end
        if (32'(q_item.sprite_len) > MAX_SPRITE_BYTES)
        begin
            n_sat = LEN_W'(MAX_SPRITE_BYTES);
        end
        else
        begin
            n_sat = LEN_W'(q_item.sprite_len);
        end
        ys = 10'($signed(q_item.y_pos));
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            psb_pkg::ST_IDLE:
            begin
                if (q_valid)
                begin
                    case (q_item.kind)
                        psb_pkg::KIND_BYTE:
                        begin
                            state_next = active ? psb_pkg::ST_READ : psb_pkg::ST_OUT;
                        end
                        psb_pkg::KIND_CLEAR: state_next = psb_pkg::ST_CLEAR;
                        psb_pkg::KIND_READ:  state_next = psb_pkg::ST_FETCH;
                        default:             state_next = psb_pkg::ST_OUT;
                    endcase
                end
            end
            psb_pkg::ST_READ:    state_next = psb_pkg::ST_MODIFY;
            psb_pkg::ST_MODIFY:
            begin
                state_next = last ? psb_pkg::ST_FLUSH_AD : psb_pkg::ST_OUT;
            end
            psb_pkg::ST_FLUSH_AD: state_next = psb_pkg::ST_FLUSH_RD;
            psb_pkg::ST_FLUSH_RD: state_next = psb_pkg::ST_FLUSH_WR;
            psb_pkg::ST_FLUSH_WR:
            begin
                state_next = (flush_reg == 7'd1) ? psb_pkg::ST_OUT : psb_pkg::ST_FLUSH_AD;
            end
            psb_pkg::ST_FETCH:   state_next = psb_pkg::ST_OUT;
            psb_pkg::ST_CLEAR:
            begin
                state_next = clr_last ? psb_pkg::ST_OUT : psb_pkg::ST_CLEAR;
            end
            psb_pkg::ST_INIT:
            begin
                state_next = clr_last ? psb_pkg::ST_IDLE : psb_pkg::ST_INIT;
            end
            psb_pkg::ST_OUT:
            begin
                if (out_ready)
                begin
                    state_next = psb_pkg::ST_IDLE;
                end
            end
            default:             state_next = psb_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        q_ready   = (state_reg == psb_pkg::ST_IDLE);
        out_valid = (state_reg == psb_pkg::ST_OUT);
        read_data = rdsel_reg ? frame_q : 8'd0;
        contact   = hit_reg;
        sprite_done = done_reg;
        vbyte     = byte_reg;
        mem_we    = 1'b0;
        mem_wa    = addr_reg;
        mem_wd    = cur | (vbyte | spill);
        if (state_reg == psb_pkg::ST_CLEAR || state_reg == psb_pkg::ST_INIT)
        begin
            mem_we = 1'b1;
            mem_wa = clr_reg;
            mem_wd = 8'd0;
        end
        else if ((state_reg == psb_pkg::ST_MODIFY || state_reg == psb_pkg::ST_FLUSH_WR)
                 && vis_reg && !test_reg)
        begin
            mem_we = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        frame_q <= frame_mem[addr_reg];
        row_q   <= row_mem[RB_W'(col_reg)];
        if (mem_we)
        begin
            frame_mem[mem_wa] <= mem_wd;
        end
        if (state_reg == psb_pkg::ST_MODIFY)
        begin
            row_mem[RB_W'(col_reg)] <= raw_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= psb_pkg::ST_INIT;
            width_reg <= 7'd1;
            len_reg   <= '0;
            x_reg     <= '0;
            ybase_reg <= '0;
            ymod_reg  <= '0;
            test_reg  <= 1'b0;
            index_reg <= '0;
            col_reg   <= '0;
            page_reg  <= '0;
            flush_reg <= '0;
            hit_reg   <= 1'b0;
            byte_reg  <= '0;
            raw_reg   <= '0;
            vis_reg   <= 1'b0;
            addr_reg  <= '0;
            clr_reg   <= '0;
            done_reg  <= 1'b0;
            rdsel_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                psb_pkg::ST_IDLE:
                begin
                    done_reg  <= 1'b0;
                    rdsel_reg <= 1'b0;
                    vis_reg   <= vis;
                    addr_reg  <= addr;
                    byte_reg  <= 8'({q_item.sprite_byte} << ymod_reg);
                    raw_reg   <= q_item.sprite_byte;
                    if (q_valid)
                    begin
                        case (q_item.kind)
                            psb_pkg::KIND_HEADER:
                            begin
                                width_reg <= w_sat;
                                len_reg   <= n_sat;
                                x_reg     <= 10'($signed(q_item.x_pos));
                                ymod_reg  <= ys[2:0];
                                ybase_reg <= 6'(ys >>> 3);
                                test_reg  <= q_item.test_only;
                                index_reg <= '0;
                                col_reg   <= '0;
                                page_reg  <= '0;
                                hit_reg   <= 1'b0;
                            end
                            psb_pkg::KIND_READ:
                            begin
                                if (32'(q_item.frame_addr) < DEPTH)
                                begin
                                    rdsel_reg <= 1'b1;
                                    addr_reg  <= ADDR_W'(q_item.frame_addr);
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                psb_pkg::ST_MODIFY, psb_pkg::ST_FLUSH_WR:
                begin
                    if (vis_reg && test_reg)
                    begin
                        if ((cur & (vbyte | spill)) != 8'd0)
                        begin
                            hit_reg <= 1'b1;
                        end
                    end
                    if (col_reg + 7'd1 >= width_reg)
                    begin
                        col_reg  <= '0;
                        page_reg <= page_reg + PG_W'(1);
                    end
                    else
                    begin
                        col_reg <= col_reg + 7'd1;
                    end
                    byte_reg <= 8'd0;
                    if (state_reg == psb_pkg::ST_MODIFY)
                    begin
                        index_reg <= index_reg + LEN_W'(1);
                        flush_reg <= width_reg;
                        done_reg  <= last;
                    end
                    else
                    begin
                        flush_reg <= flush_reg - 7'd1;
                    end
                end
                psb_pkg::ST_FLUSH_AD:
                begin
                    vis_reg  <= vis;
                    addr_reg <= addr;
                end
                psb_pkg::ST_CLEAR, psb_pkg::ST_INIT:
                begin
                    clr_reg <= clr_last ? '0 : clr_reg + ADDR_W'(1);
                end
                default:
                begin
                end
            endcase
        end
    end

endmodule

/* hdl/page_mapped_sprite_blit.sv */
// Top level of the page-mapped sprite blitter: joins the input queue and the back end.
// Depends on psb_pkg, psb_front and psb_back.
`timescale 1ns / 1ps
//  Channel | Direction | Contents
//  s_axis  | in        | one item: kind in tuser, other fields in tdata
//  m_axis  | out       | one result per item
// A header goes straight to its result, a read through the fetch state, a sprite byte through read
// and modify; the last sprite byte then flushes the overflow row, one flush pass per sprite column.
// A clear walks the frame store, writing zero to every address.
// After reset a clearing pass zeroes the frame before any transaction.
// A stalled result holds the back end; the two-entry queue then fills and drops s_axis_tready.

module page_mapped_sprite_blit
#(
    parameter int FRAME_W          = 128,
    parameter int PAGES            = 8,
    parameter int MAX_SPRITE_BYTES = 1024,
    parameter int MAX_SPRITE_W     = 127
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // sprite_width[6:0], sprite_len[17:7], x_pos[26:18], y_pos[34:27], test_only[35],
    // sprite_byte[43:36], frame_addr[53:44], zero fill to 56 bits
    input  logic [55:0] s_axis_tdata,
    // kind[1:0]
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // read_data[7:0], contact[8], sprite_done[9], zero fill to 16 bits
    output logic [15:0] m_axis_tdata
);

    psb_pkg::item_t in_item;
    psb_pkg::item_t q_item;
    logic           q_valid;
    logic           q_ready;
    logic [7:0]     read_data;
    logic           contact;
    logic           sprite_done;

    always_comb
    begin
        in_item.kind         = psb_pkg::kind_t'(s_axis_tuser);
        in_item.sprite_width = s_axis_tdata[6:0];
        in_item.sprite_len   = s_axis_tdata[17:7];
        in_item.x_pos        = s_axis_tdata[26:18];
        in_item.y_pos        = s_axis_tdata[34:27];
        in_item.test_only    = s_axis_tdata[35];
        in_item.sprite_byte  = s_axis_tdata[43:36];
        in_item.frame_addr   = s_axis_tdata[53:44];
    end

    assign m_axis_tdata = {6'd0, sprite_done, contact, read_data};

    psb_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_item  (in_item),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_item   (q_item)
    );

    psb_back
    #(
        .FRAME_W          (FRAME_W),
        .PAGES            (PAGES),
        .MAX_SPRITE_BYTES (MAX_SPRITE_BYTES),
        .MAX_SPRITE_W     (MAX_SPRITE_W)
    )
    u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_ready     (q_ready),
        .q_item      (q_item),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .read_data   (read_data),
        .contact     (contact),
        .sprite_done (sprite_done)
    );

endmodule

/* dv/testbench.sv */
// Self-checking testbench for page_mapped_sprite_blit: sprite blits, collision tests,
// frame reads and clears against a predictor of the frame store. Depends on psb_pkg and the top level.
`timescale 1ns / 1ps

class blit_scoreboard;
    bit [7:0]  frame [1024];
    bit [7:0]  row_above [128];
    int        sprite_w;
    int        sprite_n;
    int        left_col;
    int        page_base;
    int        y_shift;
    bit        testing;
    int        byte_count;
    int        col;
    int        page;
    bit        hit;
    bit [9:0]  pending [$];
    int        errors;
    int        results;

    function new();
        foreach (frame[i]) frame[i] = 0;
        sprite_w = 1;
        sprite_n = 0;
        left_col = 0;
        page_base = 0;
        y_shift = 0;
        testing = 0;
        byte_count = 0;
        col = 0;
        page = 0;
        hit = 0;
        errors = 0;
        results = 0;
    endfunction

    function bit [7:0] spill(int c);
        if (y_shift == 0 || c > 127)
            return 8'd0;
        return row_above[c] >> (8 - y_shift);
    endfunction

    function void merge(int c, int r, bit [7:0] v);
        int fx;
        int fy;
        fx = left_col + c;
        fy = page_base + r;
        if (fx < 0 || fx >= 128 || fy < 0 || fy >= 8)
            return;
        if (testing) begin
            if ((frame[fy * 128 + fx] & v) != 0)
                hit = 1;
        end
        else
            frame[fy * 128 + fx] |= v;
    endfunction

    function void step_on();
        col++;
        if (col >= sprite_w)
        begin
            col = 0;
            page++;
        end
    endfunction

    function void note_input(psb_pkg::kind_t k, bit [55:0] d);
        bit [7:0] rd;
        bit       done;
        bit [7:0] b;
        bit [7:0] v;
        int       ys;
        rd = 0;
        done = 0;
        case (k)
            psb_pkg::KIND_HEADER:
            begin
                sprite_w = d[6:0];
                if (sprite_w == 0) sprite_w = 1;
                sprite_n = d[17:7];
                if (sprite_n > 1024) sprite_n = 1024;
                left_col = $signed(d[26:18]);
                ys = $signed(d[34:27]);
                y_shift = ys & 7;
                page_base = (ys - y_shift) / 8;
                testing = d[35];
                byte_count = 0;
                col = 0;
                page = 0;
                hit = 0;
            end
            psb_pkg::KIND_BYTE:
            begin
                if (byte_count < sprite_n)
                begin
                    b = d[43:36];
                    v = b << y_shift;
                    if (page > 0) v |= spill(col);
                    merge(col, page, v);
                    row_above[col] = b;
                    step_on();
                    byte_count++;
                    if (byte_count == sprite_n)
                    begin
                        for (int i = 0; i < sprite_w; i++)
                        begin
                            merge(col, page, page > 0 ? spill(col) : 8'd0);
                            step_on();
                        end
                        done = 1;
                    end
                end
            end
            psb_pkg::KIND_READ:
                rd = frame[d[53:44]];
            default:
                foreach (frame[i]) frame[i] = 0;
        endcase
        pending.push_back({done, hit, rd});
    endfunction

    function void check_result(bit [15:0] got);
        bit [9:0] want;
        results++;
        if (pending.size() == 0)
        begin
            $display("%0t: unexpected result %h", $time, got);
            errors++;
            return;
        end
        want = pending.pop_front();
        if (got[7:0] !== want[7:0] || got[8] !== want[8] || got[9] !== want[9]
            || got[15:10] !== 6'd0)
        begin
            $display("%0t: expected read_data %h contact %b done %b, got %h %b %b",
                     $time, want[7:0], want[8], want[9], got[7:0], got[8], got[9]);
            errors++;
        end
    endfunction
endclass

module testbench;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;

    blit_scoreboard board;
    int             cycles;
    int             sprites_sent;
    int             reads_sent;

    page_mapped_sprite_blit uut
    (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    initial clk = 0;
    always #10 clk = ~clk;

    initial
    begin
        board = new();
        cycles = 0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 2000000)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    always @(posedge clk)
        if (rst_n && m_axis_tvalid && m_axis_tready)
            board.check_result(m_axis_tdata);

    initial
    begin
        int gap;
        m_axis_tready = 0;
        wait (rst_n);
        forever
        begin
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 8);
            if (gap > 0)
            begin
                m_axis_tready <= 0;
                repeat (gap) @(posedge clk);
            end
            m_axis_tready <= 1;
            @(posedge clk);
            while (!m_axis_tvalid) @(posedge clk);
        end
    end

    task automatic send(psb_pkg::kind_t k, bit [55:0] d);
        int gap;
        gap = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 8);
        if (gap > 0)
        begin
            s_axis_tvalid <= 0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tuser <= k;
        s_axis_tdata <= d;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        board.note_input(k, d);
    endtask

    task automatic hold_input();
        s_axis_tvalid <= 0;
        @(posedge clk);
    endtask

    task automatic header(bit [6:0] w, bit [10:0] n, bit [8:0] x, bit [7:0] y, bit t);
        bit [55:0] d;
        d = 56'({$urandom, $urandom});
        d[35:0] = {t, y, x, n, w};
        d[55:54] = 2'd0;
        sprites_sent++;
        send(psb_pkg::KIND_HEADER, d);
    endtask

    task automatic sprite_byte(bit [7:0] b);
        bit [55:0] d;
        d = 56'({$urandom, $urandom});
        d[43:36] = b;
        d[55:54] = 2'd0;
        send(psb_pkg::KIND_BYTE, d);
    endtask

    task automatic read_at(bit [9:0] a);
        bit [55:0] d;
        d = 56'({$urandom, $urandom});
        d[53:44] = a;
        d[55:54] = 2'd0;
        reads_sent++;
        send(psb_pkg::KIND_READ, d);
    endtask

    task automatic sprite(bit [6:0] w, bit [10:0] n, bit [8:0] x, bit [7:0] y, bit t,
                          int bytes);
        header(w, n, x, y, t);
        for (int i = 0; i < bytes; i++)
        begin
            sprite_byte(8'($urandom));
            if ($urandom_range(0, 19) == 0) read_at(10'($urandom));
        end
    endtask

    initial
    begin
        int pick;
        int w;
        int n;
        sprites_sent = 0;
        reads_sent = 0;
        rst_n = 0;
        s_axis_tvalid = 0;
        s_axis_tdata = 0;
        s_axis_tuser = psb_pkg::KIND_READ;
        repeat (2) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        read_at(10'd0);
        read_at(10'd1023);
        sprite_byte(8'hFF);
        sprite(7'd0, 11'd2, 9'd0, 8'd3, 1'b0, 2);
        sprite(7'd127, 11'd3, 9'd126, 8'd60, 1'b0, 3);
        sprite(7'd3, 11'd0, 9'd5, 8'd0, 1'b0, 0);
        sprite_byte(8'hA5);
        sprite(7'd2, 11'h7FF, 9'h100, 8'h80, 1'b0, 3);
        sprite(7'd2, 11'd4, 9'h1FF, 8'hFD, 1'b0, 4);
        sprite(7'd2, 11'd4, 9'd0, 8'd3, 1'b1, 4);
        read_at(10'd3);
        read_at(10'd130);
        send(psb_pkg::KIND_CLEAR, 56'd0);
        read_at(10'd3);

        for (int i = 0; i < 24; i++)
        begin
            pick = $urandom_range(0, 9);
            w = $urandom_range(0, 3) == 0 ? $urandom_range(0, 127) : $urandom_range(1, 6);
            n = w * $urandom_range(1, 3);
            if ($urandom_range(0, 15) == 0) n = $urandom_range(0, 2047);
            if (n > 40) n = $urandom_range(0, 1) ? 2047 : 40;
            if (pick == 0)
                send(psb_pkg::KIND_CLEAR, 56'({$urandom, $urandom}) & 56'h3F_FFFF_FFFF_FFFF);
            else if (pick == 1)
                sprite(7'(w), 11'(n), 9'($urandom), 8'($urandom), 1'($urandom),
                       $urandom_range(0, n > 40 ? 40 : n));
            else
                sprite(7'(w), 11'(n),
                       $urandom_range(0, 1) ? 9'($urandom_range(0, 140) - 10) : 9'($urandom),
                       $urandom_range(0, 1) ? 8'($urandom_range(0, 70) - 6) : 8'($urandom),
                       $urandom_range(0, 2) == 0, n > 40 ? 40 : n);
            for (int r = $urandom_range(0, 2); r > 0; r--) read_at(10'($urandom));
            if (i == 12)
            begin
                hold_input();
                while (board.pending.size() != 0) @(posedge clk);
            end
        end

        hold_input();
        while (board.pending.size() != 0) @(posedge clk);
        repeat (600) @(posedge clk);
        $display("Covered %0d sprite headers and %0d frame reads, %0d results checked.",
                 sprites_sent, reads_sent, board.results);
        if (board.errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
